FILE: hdl/swmd_pkg.sv
package swmd_pkg;

    localparam int WINDOW_MAX_DEF  = 64;
    localparam int SAMPLE_BITS_DEF = 32;

    // window size register
    localparam int               CFG_W        = 7;
    localparam logic [CFG_W-1:0] WIN_SIZE_RST = 7'd3;

    // controller to datapath
    typedef struct packed {
        logic accept;
        logic pop_head;
        logic pop_tail;
        logic push;
        logic load_out;
    } cmd_t;

    // datapath to controller
    typedef struct packed {
        logic head_expired;
        logic back_smaller;
        logic result_due;
    } status_t;

endpackage

FILE: hdl/swmd_ctrl.sv
module swmd_ctrl (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             s_valid,
    output logic             s_ready,
    output logic             m_valid,
    input  logic             m_ready,
    input  swmd_pkg::status_t status,
    output swmd_pkg::cmd_t    cmd
);

    typedef enum logic {
        ST_IDLE,
        ST_SCAN
    } state_t;

    state_t state_reg, state_next;
    logic   m_valid_reg, m_valid_next;
    logic   out_free;

    assign out_free = !m_valid_reg || m_ready;

    always_comb begin
        state_next   = state_reg;
        cmd          = '0;
        m_valid_next = m_valid_reg && !m_ready;
        unique case (state_reg)
            ST_IDLE: begin
                if (s_valid) begin
                    cmd.accept = 1'b1;
                    state_next = ST_SCAN;
                end
            end
            ST_SCAN: begin
                // one candidate leaves per cycle: expired head first, then smaller back
                if (status.head_expired) begin
                    cmd.pop_head = 1'b1;
                end else if (status.back_smaller) begin
                    cmd.pop_tail = 1'b1;
                end else if (!status.result_due || out_free) begin
                    cmd.push      = 1'b1;
                    cmd.load_out  = status.result_due;
                    m_valid_next  = status.result_due || (m_valid_reg && !m_ready);
                    state_next    = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            m_valid_reg <= m_valid_next;
        end
    end

    assign s_ready = (state_reg == ST_IDLE);
    assign m_valid = m_valid_reg;

endmodule

FILE: hdl/swmd_dp.sv
module swmd_dp #(
    parameter int WINDOW_MAX  = swmd_pkg::WINDOW_MAX_DEF,
    parameter int SAMPLE_BITS = swmd_pkg::SAMPLE_BITS_DEF
) (
    input  logic                                 aclk,
    input  logic                                 aresetn,
    input  logic                                 cfg_wr_en,
    input  logic [swmd_pkg::CFG_W-1:0]           cfg_wr_data,
    input  logic signed [SAMPLE_BITS-1:0]        s_sample,
    input  logic                                 s_first,
    input  logic                                 s_last,
    output logic signed [SAMPLE_BITS-1:0]        m_window_max,
    output logic                                 m_last_out,
    input  swmd_pkg::cmd_t                       cmd,
    output swmd_pkg::status_t                    status
);

    localparam int IDX_W = $clog2(WINDOW_MAX);
    localparam int CNT_W = $clog2(WINDOW_MAX + 1);
    localparam int TAG_W = $clog2(2 * WINDOW_MAX);
    localparam int SZ_W  = (CNT_W > swmd_pkg::CFG_W) ? CNT_W : swmd_pkg::CFG_W;
    localparam int MEM_W = TAG_W + SAMPLE_BITS;

    localparam logic [IDX_W:0]   DEPTH    = (IDX_W+1)'(WINDOW_MAX);
    localparam logic [IDX_W-1:0] SLOT_END = IDX_W'(WINDOW_MAX - 1);
    localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(WINDOW_MAX);
    localparam logic [SZ_W-1:0]  SZ_MAX   = SZ_W'(WINDOW_MAX);
    localparam logic [TAG_W-1:0] TAG_END  = TAG_W'(2 * WINDOW_MAX - 1);
    localparam logic [TAG_W:0]   TAG_MOD  = (TAG_W+1)'(2 * WINDOW_MAX);

    // candidate store: {tag, value}
    logic [MEM_W-1:0] mem [WINDOW_MAX];

    logic [swmd_pkg::CFG_W-1:0]   win_size_reg;
    logic signed [SAMPLE_BITS-1:0] sample_reg;
    logic                          last_reg;
    logic [IDX_W-1:0]              head_reg, head_next;
    logic [CNT_W-1:0]              count_reg, count_next;
    logic [TAG_W-1:0]              pos_reg, pos_next;
    logic [CNT_W-1:0]              filled_reg, filled_next;
    logic [MEM_W-1:0]              head_rd_reg, back_rd_reg;
    logic signed [SAMPLE_BITS-1:0] window_max_reg;
    logic                          last_out_reg;

    logic [SZ_W-1:0]               size_sz;
    logic [CNT_W-1:0]              size_eff;
    logic [CNT_W-1:0]              filled_inc;
    logic [IDX_W:0]                tail_sum, back_sum;
    logic [IDX_W-1:0]              tail_addr, back_addr;
    logic [MEM_W-1:0]              wr_data;
    logic [TAG_W-1:0]              head_tag;
    logic [TAG_W:0]                age;
    logic signed [SAMPLE_BITS-1:0] head_val, back_val;

    // window size, held to the queue depth
    assign size_sz  = (SZ_W'(win_size_reg) > SZ_MAX) ? SZ_MAX : SZ_W'(win_size_reg);
    assign size_eff = size_sz[CNT_W-1:0];

    assign filled_inc = (filled_reg == CNT_FULL) ? filled_reg : filled_reg + 1'b1;

    always_comb begin
        head_next   = head_reg;
        count_next  = count_reg;
        pos_next    = pos_reg;
        filled_next = filled_reg;
        if (cmd.accept && s_first) begin
            head_next   = '0;
            count_next  = '0;
            pos_next    = '0;
            filled_next = '0;
        end
        if (cmd.pop_head) begin
            head_next  = (head_reg == SLOT_END) ? '0 : head_reg + 1'b1;
            count_next = count_reg - 1'b1;
        end
        if (cmd.pop_tail) begin
            count_next = count_reg - 1'b1;
        end
        if (cmd.push) begin
            count_next  = count_reg + 1'b1;
            pos_next    = (pos_reg == TAG_END) ? '0 : pos_reg + 1'b1;
            filled_next = filled_inc;
        end
    end

    // slot after the newest candidate
    assign tail_sum  = {1'b0, head_reg} + (IDX_W+1)'(count_reg);
    assign tail_addr = (tail_sum >= DEPTH) ? IDX_W'(tail_sum - DEPTH) : tail_sum[IDX_W-1:0];

    // newest candidate as it will stand next cycle
    assign back_sum  = {1'b0, head_next} + (IDX_W+1)'(count_next) - 1'b1;
    always_comb begin
        if (count_next == '0) begin
            back_addr = head_next;
        end else if (back_sum >= DEPTH) begin
            back_addr = IDX_W'(back_sum - DEPTH);
        end else begin
            back_addr = back_sum[IDX_W-1:0];
        end
    end

    assign wr_data = {pos_reg, sample_reg};

    // read addresses follow the next pointers; a write to the same slot reads through
    always_ff @(posedge aclk) begin
        if (cmd.push) begin
            mem[tail_addr] <= wr_data;
        end
        head_rd_reg <= (cmd.push && tail_addr == head_next) ? wr_data : mem[head_next];
        back_rd_reg <= (cmd.push && tail_addr == back_addr) ? wr_data : mem[back_addr];
    end

    assign head_tag = head_rd_reg[MEM_W-1 -: TAG_W];
    assign head_val = head_rd_reg[SAMPLE_BITS-1:0];
    assign back_val = back_rd_reg[SAMPLE_BITS-1:0];

    // distance of the head from the current position, modulo the tag range
    assign age = (pos_reg >= head_tag) ? {1'b0, pos_reg} - {1'b0, head_tag}
                                       : {1'b0, pos_reg} + TAG_MOD - {1'b0, head_tag};

    assign status.head_expired = (count_reg != '0) && (age >= (TAG_W+1)'(size_eff));
    assign status.back_smaller = (count_reg != '0) && (back_val < sample_reg);
    assign status.result_due   = (size_eff != '0) && (filled_inc >= size_eff);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            win_size_reg <= swmd_pkg::WIN_SIZE_RST;
            head_reg     <= '0;
            count_reg    <= '0;
            pos_reg      <= '0;
            filled_reg   <= '0;
        end else begin
            if (cfg_wr_en) begin
                win_size_reg <= cfg_wr_data;
            end
            head_reg   <= head_next;
            count_reg  <= count_next;
            pos_reg    <= pos_next;
            filled_reg <= filled_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.accept) begin
            sample_reg <= s_sample;
            last_reg   <= s_last;
        end
        if (cmd.load_out) begin
            // empty queue after the pops: the new sample is the maximum
            window_max_reg <= (count_reg == '0) ? sample_reg : head_val;
            last_out_reg   <= last_reg;
        end
    end

    assign m_window_max = window_max_reg;
    assign m_last_out   = last_out_reg;

endmodule

FILE: hdl/sliding_window_max_deque.sv
// Sliding window maximum over a stream of signed samples, using a monotonic queue of
// candidates held in one memory of WINDOW_MAX entries. An accepted beat is registered,
// then drops candidates from the queue (expired head or smaller back entry) and is then
// pushed, waiting for the output register if a result is due; the queue memory moves
// one candidate per cycle. A sample is dropped at most once. One sample is in
// work at a time; a finished result waits in the output register while the next beat is
// taken. A result appears only once window_size samples of the current sequence have
// arrived (window sizes above WINDOW_MAX act as WINDOW_MAX, zero gives no results);
// s_first starts a new sequence and s_last is copied to m_last_out. Write cfg_wr_data
// only while no beat is in work. The queue memory needs no clearing after reset.
module sliding_window_max_deque #(
    parameter int WINDOW_MAX  = swmd_pkg::WINDOW_MAX_DEF,
    parameter int SAMPLE_BITS = swmd_pkg::SAMPLE_BITS_DEF
) (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  logic                           cfg_wr_en,
    input  logic [swmd_pkg::CFG_W-1:0]     cfg_wr_data,
    input  logic                           s_valid,
    output logic                           s_ready,
    input  logic signed [SAMPLE_BITS-1:0]  s_sample,
    input  logic                           s_first,
    input  logic                           s_last,
    output logic                           m_valid,
    input  logic                           m_ready,
    output logic signed [SAMPLE_BITS-1:0]  m_window_max,
    output logic                           m_last_out
);

    swmd_pkg::cmd_t    cmd;
    swmd_pkg::status_t status;

    swmd_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .status  (status),
        .cmd     (cmd)
    );

    swmd_dp #(
        .WINDOW_MAX  (WINDOW_MAX),
        .SAMPLE_BITS (SAMPLE_BITS)
    ) u_dp (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .cfg_wr_en    (cfg_wr_en),
        .cfg_wr_data  (cfg_wr_data),
        .s_sample     (s_sample),
        .s_first      (s_first),
        .s_last       (s_last),
        .m_window_max (m_window_max),
        .m_last_out   (m_last_out),
        .cmd          (cmd),
        .status       (status)
    );

`ifndef SYNTHESIS
    // at most one queue update per cycle
    a_one_update: assert property (@(posedge aclk) disable iff (!aresetn)
        $onehot0({cmd.pop_head, cmd.pop_tail, cmd.push}))
        else $error("more than one queue update in a cycle");

    // one sample in work at a time
    a_one_in_work: assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready |=> !s_ready)
        else $error("beat accepted while previous sample in work");

    // a result never overwrites one still waiting
    a_no_overwrite: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.load_out |-> (!m_valid || m_ready))
        else $error("output register overwritten");

    // a result is loaded only on the push that completes a sample
    a_load_on_push: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.load_out |-> cmd.push && status.result_due)
        else $error("result loaded outside a push");
`endif

endmodule
